>>> design/debounced_pulse_gust_tracker_assert.svh
// Assertion macros shared by the gust tracker modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DEBOUNCED_PULSE_GUST_TRACKER_ASSERT_SVH
`define DEBOUNCED_PULSE_GUST_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DPGT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DPGT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define DPGT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define DPGT_ASSERT_ALWAYS(lbl, cond, msg)
`define DPGT_ASSERT_IMP(lbl, pre, post, msg)
`define DPGT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> design/dpgt_pkg.sv
// Package for the debounced pulse gust tracker: constants, register indices,
// controller state type and the command and status structs. No dependencies.
package dpgt_pkg;

  localparam int GUST_DEPTH_DEFAULT  = 16;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam int TIMER_W     = 16;
  localparam int OUT_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TIMER_W-1:0] DEBOUNCE_RESET    = 16'd20;
  localparam logic [TIMER_W-1:0] GUST_PERIOD_RESET = 16'd3000;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GUST_PERIOD = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } dpgt_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic scan_rd;
    logic finish;
  } dpgt_cmd_t;

  typedef struct packed {
    logic report;
    logic scan_last;
    logic out_free;
  } dpgt_stat_t;

endpackage

>>> design/debounced_pulse_gust_tracker.sv
// Top level of the debounced pulse gust tracker: configuration registers and
// the controller and datapath instances. Depends on dpgt_pkg, dpgt_ctrl, dpgt_datapath.
//
//   Channel  Handshake             Payload
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in_valid/in_ready     wind_edge, rain_edge, report_request
//   out      out_valid/out_ready   wind_pulses, rain_pulses, gust_peak
//
// A tick without a report is accepted in ST_IDLE, then takes one update step in ST_UPDATE.
// A tick with a report goes on from ST_UPDATE to the peak scan in ST_SCAN, which
// reads one gust ring entry a cycle from the single-port ring memory.
// The result sits in an output register, so the next tick is accepted while it waits.
// Reset clears all counters, timers and ring valid bits at once; no clearing pass.
// Configuration writes are taken in every cycle.
module debounced_pulse_gust_tracker
  import dpgt_pkg::*;
#(
  parameter int GUST_DEPTH  = GUST_DEPTH_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   wind_edge,
  input  logic                   rain_edge,
  input  logic                   report_request,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       wind_pulses,
  output logic [OUT_W-1:0]       rain_pulses,
  output logic [OUT_W-1:0]       gust_peak
);

  logic [TIMER_W-1:0] debounce_ms;
  logic [TIMER_W-1:0] gust_period;
  dpgt_cmd_t          cmd;
  dpgt_stat_t         stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      gust_period <= GUST_PERIOD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS: debounce_ms <= TIMER_W'(cfg_data);
        CFG_GUST_PERIOD: gust_period <= TIMER_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  dpgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dpgt_datapath #(
    .GUST_DEPTH  (GUST_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .debounce_ms    (debounce_ms),
    .gust_period    (gust_period),
    .wind_edge      (wind_edge),
    .rain_edge      (rain_edge),
    .report_request (report_request),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .wind_pulses    (wind_pulses),
    .rain_pulses    (rain_pulses),
    .gust_peak      (gust_peak)
  );

endmodule

>>> design/dpgt_ctrl.sv
// Controller state machine for the gust tracker.
// Depends on dpgt_pkg and the assertion macro header.
`include "debounced_pulse_gust_tracker_assert.svh"

module dpgt_ctrl
  import dpgt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dpgt_stat_t stat,
  output dpgt_cmd_t  cmd
);

  dpgt_state_t state;
  dpgt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.step   = 1'b1;
        state_next = stat.report ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `DPGT_ASSERT_NEXT(a_accept_updates, in_valid && in_ready, state == ST_UPDATE, "accepted transaction not processed")
  `DPGT_ASSERT_NEXT(a_scan_continues, state == ST_SCAN && !stat.scan_last, state == ST_SCAN, "ring scan ended early")

endmodule

>>> design/dpgt_datapath.sv
// Datapath for the gust tracker: debounce timers, pulse counters, gust ring
// memory with per-slot valid bits, peak scan and output register. Uses dpgt_pkg.
`include "debounced_pulse_gust_tracker_assert.svh"

module dpgt_datapath
  import dpgt_pkg::*;
#(
  parameter int GUST_DEPTH  = GUST_DEPTH_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  dpgt_cmd_t          cmd,
  output dpgt_stat_t         stat,
  input  logic [TIMER_W-1:0] debounce_ms,
  input  logic [TIMER_W-1:0] gust_period,
  input  logic               wind_edge,
  input  logic               rain_edge,
  input  logic               report_request,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [OUT_W-1:0]   wind_pulses,
  output logic [OUT_W-1:0]   rain_pulses,
  output logic [OUT_W-1:0]   gust_peak
);

  localparam int IW = (GUST_DEPTH > 1) ? $clog2(GUST_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(GUST_DEPTH - 1);

  function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH-1:0] high;
    high = v >> OUT_W;
    if (COUNT_WIDTH > OUT_W && high != '0) begin
      return '1;
    end
    return OUT_W'(v);
  endfunction

  logic                   wind_req;
  logic                   rain_req;
  logic                   rep_req;
  logic [TIMER_W-1:0]     wind_since;
  logic [TIMER_W-1:0]     rain_since;
  logic [TIMER_W-1:0]     gust_since;
  logic [COUNT_WIDTH-1:0] wind_count;
  logic [COUNT_WIDTH-1:0] rain_count;
  logic [COUNT_WIDTH-1:0] prev_wind_count;
  logic [IW-1:0]          gust_slot;
  logic [IW-1:0]          scan_idx;
  logic [COUNT_WIDTH-1:0] ring_mem [GUST_DEPTH];
  logic [GUST_DEPTH-1:0]  ring_ok;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_ok;
  logic                   rd_live;
  logic [COUNT_WIDTH-1:0] peak;

  logic [TIMER_W-1:0]     wind_since_up;
  logic [TIMER_W-1:0]     rain_since_up;
  logic [TIMER_W-1:0]     gust_since_up;
  logic                   wind_hit;
  logic                   rain_hit;
  logic                   sample;
  logic [COUNT_WIDTH-1:0] wind_count_next;
  logic [COUNT_WIDTH-1:0] rain_count_next;
  logic [COUNT_WIDTH-1:0] revs;
  logic [IW-1:0]          gust_slot_next;

  always_comb begin
    wind_since_up = (wind_since == '1) ? wind_since : wind_since + 1'b1;
    rain_since_up = (rain_since == '1) ? rain_since : rain_since + 1'b1;
    gust_since_up = (gust_since == '1) ? gust_since : gust_since + 1'b1;
    wind_hit = wind_req && (wind_since_up >= debounce_ms);
    rain_hit = rain_req && (rain_since_up >= debounce_ms);
    sample   = gust_since_up >= gust_period;
    wind_count_next = wind_count;
    if (wind_hit && wind_count != '1) begin
      wind_count_next = wind_count + 1'b1;
    end
    rain_count_next = rain_count;
    if (rain_hit && rain_count != '1) begin
      rain_count_next = rain_count + 1'b1;
    end
    revs = (wind_count_next >= prev_wind_count) ? wind_count_next - prev_wind_count : '0;
    gust_slot_next = (gust_slot == LAST_SLOT) ? '0 : gust_slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wind_since      <= '0;
      rain_since      <= '0;
      gust_since      <= '0;
      wind_count      <= '0;
      rain_count      <= '0;
      prev_wind_count <= '0;
      gust_slot       <= '0;
      scan_idx        <= '0;
      ring_ok         <= '0;
      rd_live         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      rd_live <= cmd.scan_rd;
      if (cmd.step) begin
        wind_since <= wind_hit ? '0 : wind_since_up;
        rain_since <= rain_hit ? '0 : rain_since_up;
        wind_count <= wind_count_next;
        rain_count <= rain_count_next;
        scan_idx   <= '0;
        if (sample) begin
          gust_since         <= '0;
          prev_wind_count    <= wind_count_next;
          gust_slot          <= gust_slot_next;
          ring_ok[gust_slot] <= 1'b1;
        end else begin
          gust_since <= gust_since_up;
        end
      end
      if (cmd.scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.finish) begin
        wind_count      <= '0;
        rain_count      <= '0;
        prev_wind_count <= '0;
        gust_slot       <= '0;
        ring_ok         <= '0;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wind_req <= wind_edge;
      rain_req <= rain_edge;
      rep_req  <= report_request;
    end
    if (cmd.step && sample) begin
      ring_mem[gust_slot] <= revs;
    end
    if (cmd.scan_rd) begin
      rd_data <= ring_mem[scan_idx];
      rd_ok   <= ring_ok[scan_idx];
    end
    if (cmd.step) begin
      peak <= '0;
    end else if (rd_live && rd_ok && rd_data > peak) begin
      peak <= rd_data;
    end
    if (cmd.finish) begin
      wind_pulses <= clamp_out(wind_count);
      rain_pulses <= clamp_out(rain_count);
      gust_peak   <= clamp_out(peak);
    end
  end

  assign stat.report    = rep_req;
  assign stat.scan_last = scan_idx == LAST_SLOT;
  assign stat.out_free  = !out_valid || out_ready;

  `DPGT_ASSERT_ALWAYS(a_slot_in_range, gust_slot <= LAST_SLOT, "gust slot beyond ring depth")
  `DPGT_ASSERT_NEXT(a_finish_clears, cmd.finish, wind_count == '0 && rain_count == '0 && ring_ok == '0, "report did not clear the counts and ring")
  `DPGT_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid, "report result not presented")

endmodule
